// ===== hdl/hrpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Head-relative point projection package
// Shared constants, configuration types and the roll CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrpp_pkg;

  // Angle units are 1/2^ANGLE_FRAC_BITS degree.
  localparam int ANGLE_FRAC_BITS = 6;

  // Fixed field widths of the ports.
  localparam int AZ_W   = 15;
  localparam int PIT_W  = 14;
  localparam int ROLL_W = 15;
  localparam int TOL_W  = 14;
  localparam int CX_W   = 7;
  localparam int CY_W   = 6;
  localparam int SCR_W  = 10;
  localparam int DP_W   = PIT_W + 1;  // pitch difference width

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_AZIMUTH     = 3'd0,
    REG_HEAD_PITCH       = 3'd1,
    REG_HEAD_ROLL        = 3'd2,
    REG_WINDOW_TOLERANCE = 3'd3,
    REG_CENTER_X         = 3'd4,
    REG_CENTER_Y         = 3'd5,
    REG_ROLL_ENABLE      = 3'd6
  } cfg_reg_t;

  // Reset values.
  localparam int TOL_RESET_DEG = 40;
  localparam int CX_RESET      = 63;
  localparam int CY_RESET      = 31;

  // Roll trigonometry: Q2.16 results, Q30 CORDIC vector, degrees * 2^16 angle.
  localparam int TRIG_W       = 18;
  localparam int TRIG_ONE     = 65536;
  localparam int XY_W         = 33;
  localparam int K_Q30        = 652032874;
  localparam int CORDIC_ITERS = 16;
  localparam int IT_W         = 4;
  localparam int DEG_FRAC     = 16;
  localparam int ATAN_W       = 23;
  localparam int ROUND_SHIFT  = 14;
  localparam int ROUND_HALF   = 8192;

  // Screen geometry.
  localparam int PIX_PER_DEG  = 5;
  localparam int SCREEN_W_MAX = 127;
  localparam int SCREEN_H_MAX = 63;
  localparam int SCR_MAX      = 511;
  localparam int SCR_MIN      = -512;

  // Width of the signed azimuth offset after the wrap correction.
  function automatic int offset_width(input int frac);
    offset_width = $clog2(32768 + (360 << frac)) + 1;
  endfunction

  // atan(2^-i) in degrees * 65536.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [IT_W-1:0] i);
    logic [ATAN_W-1:0] v;
    unique case (i)
      4'd0:  v = 23'd2949120;
      4'd1:  v = 23'd1740967;
      4'd2:  v = 23'd919879;
      4'd3:  v = 23'd466945;
      4'd4:  v = 23'd234379;
      4'd5:  v = 23'd117304;
      4'd6:  v = 23'd58666;
      4'd7:  v = 23'd29335;
      4'd8:  v = 23'd14668;
      4'd9:  v = 23'd7334;
      4'd10: v = 23'd3667;
      4'd11: v = 23'd1833;
      4'd12: v = 23'd917;
      4'd13: v = 23'd458;
      4'd14: v = 23'd229;
      4'd15: v = 23'd115;
      default: v = '0;
    endcase
    atan_deg = v;
  endfunction

  // Window test settings seen by the front.
  typedef struct packed {
    logic [AZ_W-1:0]         head_azimuth;
    logic signed [PIT_W-1:0] head_pitch;
    logic [TOL_W-1:0]        window_tolerance;
  } win_cfg_t;

  // Projection settings seen by the back.
  typedef struct packed {
    logic                     roll_enable;
    logic signed [TRIG_W-1:0] roll_cosine;
    logic signed [TRIG_W-1:0] roll_sine;
    logic [CX_W-1:0]          center_x;
    logic [CY_W-1:0]          center_y;
  } proj_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/hrpp_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers and roll CORDIC
// Holds the pose and screen settings and turns a roll write into cosine and
// sine with a 16-step iterative CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpp_cfg #(
  parameter int ANGLE_FRAC_BITS = hrpp_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hrpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hrpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   busy,
  output hrpp_pkg::win_cfg_t                     win_cfg,
  output hrpp_pkg::proj_cfg_t                    proj_cfg
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int ZSH   = hrpp_pkg::DEG_FRAC - F;
  localparam int ZRAW  = hrpp_pkg::ROLL_W + ZSH;
  localparam int ZW    = (ZRAW > 26 ? ZRAW : 26) + 1;
  localparam int XYW   = hrpp_pkg::XY_W;
  localparam int TW    = hrpp_pkg::TRIG_W;
  localparam int ITW   = hrpp_pkg::IT_W;

  localparam logic signed [ZW-1:0] Z_FULL    = ZW'(360 * 65536);
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 65536);
  localparam logic [31:0]          TOL_RST   = 32'(hrpp_pkg::TOL_RESET_DEG) << F;
  localparam logic signed [TW-1:0] T_ONE     = TW'(hrpp_pkg::TRIG_ONE);
  localparam logic [ITW-1:0]       IT_LAST   = ITW'(hrpp_pkg::CORDIC_ITERS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_FOLD   = 5'b00100,
    ST_ITER   = 5'b01000,
    ST_DONE   = 5'b10000
  } roll_state_t;

  roll_state_t state;

  logic signed [ZW-1:0]  z;
  logic signed [XYW-1:0] x;
  logic signed [XYW-1:0] y;
  logic [ITW-1:0]        it;
  logic                  neg;

  logic signed [ZW-1:0]  z_half_fold;
  logic signed [ZW-1:0]  z_fold;
  logic                  neg_fold;
  logic signed [XYW-1:0] x_sh;
  logic signed [XYW-1:0] y_sh;
  logic signed [ZW-1:0]  atan_step;
  logic signed [XYW-1:0] x_rnd;
  logic signed [XYW-1:0] y_rnd;
  logic                  wr;

  assign cfg_ready = (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign wr        = cfg_valid && cfg_ready;

  // Fold the reduced angle into -90..90 degrees, remembering a half turn.
  always_comb begin
    if (z >= Z_HALF) begin
      z_half_fold = z - Z_FULL;
    end else if (z < -Z_HALF) begin
      z_half_fold = z + Z_FULL;
    end else begin
      z_half_fold = z;
    end
    if (z_half_fold > Z_QUARTER) begin
      z_fold   = z_half_fold - Z_HALF;
      neg_fold = 1'b1;
    end else if (z_half_fold < -Z_QUARTER) begin
      z_fold   = z_half_fold + Z_HALF;
      neg_fold = 1'b1;
    end else begin
      z_fold   = z_half_fold;
      neg_fold = 1'b0;
    end
  end

  assign x_sh      = x >>> it;
  assign y_sh      = y >>> it;
  assign atan_step = $signed(ZW'(hrpp_pkg::atan_deg(it)));
  assign x_rnd     = (x + XYW'(hrpp_pkg::ROUND_HALF)) >>> hrpp_pkg::ROUND_SHIFT;
  assign y_rnd     = (y + XYW'(hrpp_pkg::ROUND_HALF)) >>> hrpp_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state                     <= ST_IDLE;
      win_cfg.head_azimuth      <= '0;
      win_cfg.head_pitch        <= '0;
      win_cfg.window_tolerance  <= TOL_RST[hrpp_pkg::TOL_W-1:0];
      proj_cfg.center_x         <= hrpp_pkg::CX_W'(hrpp_pkg::CX_RESET);
      proj_cfg.center_y         <= hrpp_pkg::CY_W'(hrpp_pkg::CY_RESET);
      proj_cfg.roll_enable      <= 1'b1;
      proj_cfg.roll_cosine      <= T_ONE;
      proj_cfg.roll_sine        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (wr) begin
            unique case (hrpp_pkg::cfg_reg_t'(cfg_index))
              hrpp_pkg::REG_HEAD_AZIMUTH:
                win_cfg.head_azimuth <= cfg_data[hrpp_pkg::AZ_W-1:0];
              hrpp_pkg::REG_HEAD_PITCH:
                win_cfg.head_pitch <= $signed(cfg_data[hrpp_pkg::PIT_W-1:0]);
              hrpp_pkg::REG_HEAD_ROLL: begin
                z     <= ZW'($signed(cfg_data[hrpp_pkg::ROLL_W-1:0])) <<< ZSH;
                state <= ST_REDUCE;
              end
              hrpp_pkg::REG_WINDOW_TOLERANCE:
                win_cfg.window_tolerance <= cfg_data[hrpp_pkg::TOL_W-1:0];
              hrpp_pkg::REG_CENTER_X:
                proj_cfg.center_x <= cfg_data[hrpp_pkg::CX_W-1:0];
              hrpp_pkg::REG_CENTER_Y:
                proj_cfg.center_y <= cfg_data[hrpp_pkg::CY_W-1:0];
              hrpp_pkg::REG_ROLL_ENABLE:
                proj_cfg.roll_enable <= cfg_data[0];
              default: ;
            endcase
          end
        end
        ST_REDUCE: begin
          // Remainder by a full turn, keeping the sign of the angle.
          if (z >= Z_FULL) begin
            z <= z - Z_FULL;
          end else if (z <= -Z_FULL) begin
            z <= z + Z_FULL;
          end else begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          neg <= neg_fold;
          if (z_fold == '0) begin
            proj_cfg.roll_cosine <= neg_fold ? -T_ONE : T_ONE;
            proj_cfg.roll_sine   <= '0;
            state                <= ST_IDLE;
          end else begin
            z     <= z_fold;
            x     <= XYW'(hrpp_pkg::K_Q30);
            y     <= '0;
            it    <= '0;
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (!z[ZW-1]) begin
            x <= x - y_sh;
            y <= y + x_sh;
            z <= z - atan_step;
          end else begin
            x <= x + y_sh;
            y <= y - x_sh;
            z <= z + atan_step;
          end
          it <= it + 1'b1;
          if (it == IT_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          proj_cfg.roll_cosine <= neg ? -x_rnd[TW-1:0] : x_rnd[TW-1:0];
          proj_cfg.roll_sine   <= neg ? -y_rnd[TW-1:0] : y_rnd[TW-1:0];
          state                <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrpp_front.sv =====
// ----------------------------------------------------------------------------
// Front: window test and offsets
// Accepts a point, tests it against the view window and forms the wrapped
// head-minus-target offsets for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpp_front #(
  parameter int ANGLE_FRAC_BITS = hrpp_pkg::ANGLE_FRAC_BITS,
  parameter int AW = hrpp_pkg::offset_width(ANGLE_FRAC_BITS)
) (
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [hrpp_pkg::AZ_W-1:0]          point_azimuth,
  input  wire logic signed [hrpp_pkg::PIT_W-1:0]  point_pitch,
  input  wire logic                               queue_full,
  input  wire logic                               busy,
  input  wire hrpp_pkg::win_cfg_t                 win_cfg,
  output logic                                    push,
  output logic                                    in_window,
  output logic signed [AW-1:0]                    az_off,
  output logic signed [hrpp_pkg::DP_W-1:0]        pitch_off
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int DW = AW + 1;
  localparam logic signed [AW-1:0] A_FULL = AW'(360 << F);
  localparam logic signed [AW-1:0] A_HALF = AW'(180 << F);
  localparam logic signed [DW-1:0] D_FULL = DW'(360 << F);

  logic signed [DW-1:0]                 az_diff;
  logic signed [DW-1:0]                 az_dist;
  logic signed [DW-1:0]                 az_wrap;
  logic signed [DW-1:0]                 tol;
  logic signed [hrpp_pkg::DP_W-1:0]     pitch_diff;
  logic [hrpp_pkg::DP_W-1:0]            pitch_dist;
  logic signed [AW-1:0]                 az_raw;

  assign in_ready = !queue_full && !busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    tol     = $signed(DW'(win_cfg.window_tolerance));
    az_diff = $signed(DW'(point_azimuth)) - $signed(DW'(win_cfg.head_azimuth));
    az_dist = az_diff[DW-1] ? -az_diff : az_diff;
    in_window = 1'b1;
    // One correction by a full turn less the tolerance for the wrap.
    az_wrap = az_dist;
    if (az_dist > tol) begin
      az_wrap = az_dist - D_FULL + tol;
    end
    if (az_wrap > tol || az_wrap[DW-1]) begin
      in_window = 1'b0;
    end
    pitch_diff = hrpp_pkg::DP_W'(point_pitch) - hrpp_pkg::DP_W'(win_cfg.head_pitch);
    pitch_dist = pitch_diff[hrpp_pkg::DP_W-1] ? -pitch_diff : pitch_diff;
    if (DW'(pitch_dist) > DW'(win_cfg.window_tolerance)) begin
      in_window = 1'b0;
    end

    az_raw = $signed(AW'(win_cfg.head_azimuth)) - $signed(AW'(point_azimuth));
    if (az_raw < -A_HALF) begin
      az_off = az_raw + A_FULL;
    end else if (az_raw > A_HALF) begin
      az_off = az_raw - A_FULL;
    end else begin
      az_off = az_raw;
    end
    pitch_off = hrpp_pkg::DP_W'(win_cfg.head_pitch) - hrpp_pkg::DP_W'(point_pitch);
  end

endmodule

`default_nettype wire

// ===== hdl/hrpp_queue.sv =====
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the front from the back so that each side can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpp_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrpp_back.sv =====
// ----------------------------------------------------------------------------
// Back: rotation and screen mapping
// Three-stage pipeline: products, rotated sums scaled by five, then the
// truncating scale, centering, mirroring and saturation into the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hrpp_back #(
  parameter int ANGLE_FRAC_BITS = hrpp_pkg::ANGLE_FRAC_BITS,
  parameter int AW = hrpp_pkg::offset_width(ANGLE_FRAC_BITS)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  input  wire logic                               q_inside,
  input  wire logic signed [AW-1:0]               q_az_off,
  input  wire logic signed [hrpp_pkg::DP_W-1:0]   q_pitch_off,
  input  wire hrpp_pkg::proj_cfg_t                proj_cfg,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    in_frame,
  output logic signed [hrpp_pkg::SCR_W-1:0]       screen_x,
  output logic signed [hrpp_pkg::SCR_W-1:0]       screen_y
);

  localparam int TW  = hrpp_pkg::TRIG_W;
  localparam int PW  = AW + TW;
  localparam int SW  = PW + 1;
  localparam int MW  = SW + 3;
  localparam int K   = ANGLE_FRAC_BITS + hrpp_pkg::DEG_FRAC;
  localparam int XW  = MW - K;
  localparam int XW2 = XW + 2;
  localparam logic signed [MW-1:0]  BIAS  = MW'((64'd1 << K) - 64'd1);
  localparam logic signed [XW2-1:0] X_MAX = XW2'(hrpp_pkg::SCREEN_W_MAX);
  localparam logic signed [XW2-1:0] Y_MAX = XW2'(hrpp_pkg::SCREEN_H_MAX);
  localparam logic signed [XW2-1:0] S_HI  = XW2'(hrpp_pkg::SCR_MAX);
  localparam logic signed [XW2-1:0] S_LO  = XW2'(hrpp_pkg::SCR_MIN);

  logic                     adv;
  logic signed [TW-1:0]     cos_eff;
  logic signed [TW-1:0]     sin_eff;

  // Stage 1: products.
  logic                     v1;
  logic                     in1;
  logic signed [PW-1:0]     m_ac;
  logic signed [PW-1:0]     m_ps;
  logic signed [PW-1:0]     m_pc;
  logic signed [PW-1:0]     m_as;

  // Stage 2: rotated values times five.
  logic                     v2;
  logic                     in2;
  logic signed [MW-1:0]     rx5;
  logic signed [MW-1:0]     ry5;

  // Stage 3 logic.
  logic signed [MW-1:0]     bx;
  logic signed [MW-1:0]     by;
  logic signed [XW-1:0]     xo;
  logic signed [XW-1:0]     yo;
  logic signed [XW2-1:0]    sx_full;
  logic signed [XW2-1:0]    sy_full;
  logic signed [hrpp_pkg::SCR_W-1:0] sx;
  logic signed [hrpp_pkg::SCR_W-1:0] sy;

  // The whole pipeline moves unless a finished beat is held at the output.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && q_valid;

  // Without roll the rotation is the identity in Q16, which gives the same
  // truncated pixel offsets.
  assign cos_eff = proj_cfg.roll_enable ? proj_cfg.roll_cosine : TW'(hrpp_pkg::TRIG_ONE);
  assign sin_eff = proj_cfg.roll_enable ? proj_cfg.roll_sine : '0;

  always_comb begin
    bx = rx5 + (rx5[MW-1] ? BIAS : '0);
    by = ry5 + (ry5[MW-1] ? BIAS : '0);
    xo = XW'(bx >>> K);
    yo = XW'(by >>> K);
    sx_full = X_MAX - XW2'(xo) - $signed(XW2'(proj_cfg.center_x));
    sy_full = Y_MAX - XW2'(yo) - $signed(XW2'(proj_cfg.center_y));
    if (sx_full > S_HI) begin
      sx = hrpp_pkg::SCR_W'(hrpp_pkg::SCR_MAX);
    end else if (sx_full < S_LO) begin
      sx = hrpp_pkg::SCR_W'(hrpp_pkg::SCR_MIN);
    end else begin
      sx = sx_full[hrpp_pkg::SCR_W-1:0];
    end
    if (sy_full > S_HI) begin
      sy = hrpp_pkg::SCR_W'(hrpp_pkg::SCR_MAX);
    end else if (sy_full < S_LO) begin
      sy = hrpp_pkg::SCR_W'(hrpp_pkg::SCR_MIN);
    end else begin
      sy = sy_full[hrpp_pkg::SCR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in1  <= q_inside;
      m_ac <= q_az_off * cos_eff;
      m_ps <= q_pitch_off * sin_eff;
      m_pc <= q_pitch_off * cos_eff;
      m_as <= q_az_off * sin_eff;
      in2  <= in1;
      rx5  <= (SW'(m_ac) + SW'(m_ps)) * MW'(hrpp_pkg::PIX_PER_DEG);
      ry5  <= (SW'(m_pc) - SW'(m_as)) * MW'(hrpp_pkg::PIX_PER_DEG);
      in_frame <= in2;
      screen_x <= sx;
      screen_y <= sy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/head_relative_point_projection.sv =====
// Path: an accepted point is written into the queue, then passes the product
// stage, rotated-sum stage and output register. Throughput: one point per
// cycle, every stage taking a new beat each cycle, while no roll update runs
// and no output beat is held. A head_roll write keeps cfg_ready and in_ready
// low until the new cosine and sine are written. Reset restores the register
// reset values, sets roll cosine to one and sine to zero.
// ----------------------------------------------------------------------------
// Head-relative point projection, top level
// Window test and roll-rotated screen projection of target directions.
// ----------------------------------------------------------------------------
`default_nettype none

module head_relative_point_projection #(
  parameter int ANGLE_FRAC_BITS = hrpp_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hrpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hrpp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Point input channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [hrpp_pkg::AZ_W-1:0]         point_azimuth,
  input  wire logic signed [hrpp_pkg::PIT_W-1:0] point_pitch,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   in_frame,
  output logic signed [hrpp_pkg::SCR_W-1:0]      screen_x,
  output logic signed [hrpp_pkg::SCR_W-1:0]      screen_y
);

  // Width of the wrapped azimuth offset; it grows with the angle resolution
  // because a full turn is 360 << ANGLE_FRAC_BITS units.
  localparam int AW = hrpp_pkg::offset_width(ANGLE_FRAC_BITS);
  // One queue entry carries the window flag and both offsets.
  localparam int QW = 1 + AW + hrpp_pkg::DP_W;

  logic                              busy;
  hrpp_pkg::win_cfg_t                win_cfg;
  hrpp_pkg::proj_cfg_t               proj_cfg;

  logic                              push;
  logic                              in_window;
  logic signed [AW-1:0]              az_off;
  logic signed [hrpp_pkg::DP_W-1:0]  pitch_off;

  logic                              queue_full;
  logic                              queue_not_empty;
  logic                              queue_pop;
  logic [QW-1:0]                     queue_in;
  logic [QW-1:0]                     queue_out;

  // Configuration registers. A roll write starts the CORDIC, which holds
  // both the configuration and the point channels off until the new cosine
  // and sine are in place, so no point ever sees a half-finished rotation.
  hrpp_cfg #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .win_cfg   (win_cfg),
    .proj_cfg  (proj_cfg)
  );

  // Front: accepts a beat whenever the queue has room and no roll update runs, and classifies it.
  hrpp_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .AW              (AW)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .point_azimuth (point_azimuth),
    .point_pitch   (point_pitch),
    .queue_full    (queue_full),
    .busy          (busy),
    .win_cfg       (win_cfg),
    .push          (push),
    .in_window     (in_window),
    .az_off        (az_off),
    .pitch_off     (pitch_off)
  );

  assign queue_in = {in_window, az_off, pitch_off};

  // The queue lets the front keep taking points while the back is stalled
  // on a held output beat, and vice versa.
  hrpp_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (queue_in),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_data  (queue_out)
  );

  // Back: rotation, scaling and screen mapping into the output register.
  hrpp_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .AW              (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (queue_not_empty),
    .q_pop       (queue_pop),
    .q_inside    (queue_out[QW-1]),
    .q_az_off    ($signed(queue_out[QW-2:hrpp_pkg::DP_W])),
    .q_pitch_off ($signed(queue_out[hrpp_pkg::DP_W-1:0])),
    .proj_cfg    (proj_cfg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .in_frame    (in_frame),
    .screen_x    (screen_x),
    .screen_y    (screen_y)
  );

endmodule

`default_nettype wire
